// ===== hdl/mmtb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmtb_pkg: shared types and constants
// Field widths, codes, default sizes and the command and status words that
// pass between the controller and the datapath of the matrix multiplier.
// ----------------------------------------------------------------------------
package mmtb_pkg;

	localparam int MAX_ROWS_DEF  = 8;
	localparam int MAX_COLS_DEF  = 8;
	localparam int MAX_DEPTH_DEF = 64;

	localparam int ACTION_W    = 2;
	localparam int ROW_W       = 3;
	localparam int DEPTH_IDX_W = 6;
	localparam int ELEM_W      = 16;
	localparam int PROD_W      = 2 * ELEM_W;
	localparam int VALUE_W     = 38;

	localparam int CNT_W       = 4;
	localparam int DEPTH_CNT_W = 7;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CNT_W-1:0]       RST_ROWS  = CNT_W'(8);
	localparam logic [CNT_W-1:0]       RST_COLS  = CNT_W'(8);
	localparam logic [DEPTH_CNT_W-1:0] RST_DEPTH = DEPTH_CNT_W'(64);

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD_A = 2'd0,
		ACT_LOAD_B = 2'd1,
		ACT_RUN    = 2'd2
	} action_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROWS  = 2'd0,
		REG_COLS  = 2'd1,
		REG_DEPTH = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic wr_a;
		logic wr_b;
		logic issue;
		logic first;
		logic last_beat;
		logic last_result;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_full;
	} dp_status_t;

	function automatic int width_of(input int n);
		return (n <= 1) ? 1 : $clog2(n);
	endfunction

	function automatic int clamp_count(input int v, input int maxv);
		if (v < 1) begin
			return 1;
		end
		if (v > maxv) begin
			return maxv;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/mmtb_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmtb_ifs: channel interfaces
// Input, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mmtb_req_if;
	logic                              valid;
	logic                              ready;
	logic [mmtb_pkg::ACTION_W-1:0]     action;
	logic [mmtb_pkg::ROW_W-1:0]        row_index;
	logic [mmtb_pkg::DEPTH_IDX_W-1:0]  depth_index;
	logic signed [mmtb_pkg::ELEM_W-1:0] element_value;

	modport source (output valid, action, row_index, depth_index, element_value,
		input ready);
	modport sink (input valid, action, row_index, depth_index, element_value,
		output ready);
endinterface

interface mmtb_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [mmtb_pkg::ROW_W-1:0]          out_row;
	logic [mmtb_pkg::ROW_W-1:0]          out_col;
	logic signed [mmtb_pkg::VALUE_W-1:0] out_value;
	logic                                last_result;

	modport source (output valid, out_row, out_col, out_value, last_result,
		input ready);
	modport sink (input valid, out_row, out_col, out_value, last_result,
		output ready);
endinterface

interface mmtb_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [mmtb_pkg::CFG_INDEX_W-1:0] index;
	logic [mmtb_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/matrix_multiply_transposed_b.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_transposed_b: C = A times the transpose of B
// Input words on req either load one signed Q8.8 element of A or of B, or
// start a run. Loads give no result. A run sends every C[i][j] on rsp in
// row-major order, each the exact dot product of A row i and B row j with
// 16 fraction bits; the final word of a run carries last_result. Sizes come
// from the three registers written on cfg (rows, columns, depth), which are
// clamped into range when a run starts. One multiply-accumulate unit serves
// the whole run, one depth step a cycle within a dot product; a new dot
// product starts only once the pipeline has drained and the result register
// is empty. req is held off during a run. The result register holds a word
// until rsp.ready; while it is stalled the next dot product does not start.
// After a load or the end of a run, req is ready again even while the last
// result still waits.
// Reset sets the sizes to 8, 8 and 64. The element stores are not cleared;
// only elements that have been loaded may be used by a run.
// ----------------------------------------------------------------------------
module matrix_multiply_transposed_b #(
	parameter int MAX_ROWS  = mmtb_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS  = mmtb_pkg::MAX_COLS_DEF,
	parameter int MAX_DEPTH = mmtb_pkg::MAX_DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	mmtb_req_if.sink   req,
	mmtb_rsp_if.source rsp,
	mmtb_cfg_if.sink   cfg
);

	mmtb_pkg::dp_cmd_t                            cmd;
	mmtb_pkg::dp_status_t                         st;
	logic [mmtb_pkg::width_of(MAX_ROWS)-1:0]      rd_row_a;
	logic [mmtb_pkg::width_of(MAX_COLS)-1:0]      rd_row_b;
	logic [mmtb_pkg::width_of(MAX_DEPTH)-1:0]     rd_depth;

	mmtb_ctrl #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.MAX_DEPTH (MAX_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.st       (st),
		.cmd      (cmd),
		.rd_row_a (rd_row_a),
		.rd_row_b (rd_row_b),
		.rd_depth (rd_depth)
	);

	mmtb_dp #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.MAX_DEPTH (MAX_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.ld_row   (req.row_index),
		.ld_depth (req.depth_index),
		.ld_value (req.element_value),
		.rd_row_a (rd_row_a),
		.rd_row_b (rd_row_b),
		.rd_depth (rd_depth),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

// ===== hdl/mmtb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmtb_ctrl: run sequencer
// Holds the size registers, accepts input words and steps the row, column
// and depth counters that drive the datapath during a run.
// ----------------------------------------------------------------------------
module mmtb_ctrl #(
	parameter int MAX_ROWS  = mmtb_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS  = mmtb_pkg::MAX_COLS_DEF,
	parameter int MAX_DEPTH = mmtb_pkg::MAX_DEPTH_DEF
) (
	input  wire                                         clk,
	input  wire                                         arst_n,
	mmtb_req_if.sink                                    req,
	mmtb_cfg_if.sink                                    cfg,
	input  mmtb_pkg::dp_status_t                        st,
	output mmtb_pkg::dp_cmd_t                           cmd,
	output logic [mmtb_pkg::width_of(MAX_ROWS)-1:0]     rd_row_a,
	output logic [mmtb_pkg::width_of(MAX_COLS)-1:0]     rd_row_b,
	output logic [mmtb_pkg::width_of(MAX_DEPTH)-1:0]    rd_depth
);

	localparam int RW = mmtb_pkg::width_of(MAX_ROWS);
	localparam int CW = mmtb_pkg::width_of(MAX_COLS);
	localparam int DW = mmtb_pkg::width_of(MAX_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_ISSUE
	} state_t;

	state_t                             state_q;
	logic [RW-1:0]                      i_q, last_i_q;
	logic [CW-1:0]                      j_q, last_j_q;
	logic [DW-1:0]                      p_q, last_p_q;
	logic [mmtb_pkg::CNT_W-1:0]         rows_q, cols_q;
	logic [mmtb_pkg::DEPTH_CNT_W-1:0]   depth_q;
	logic                               accept;
	logic                               row_ok_a, row_ok_b, depth_ok;
	logic                               end_p, end_j, end_i;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && req.ready;

	assign row_ok_a = (32'(req.row_index) < MAX_ROWS);
	assign row_ok_b = (32'(req.row_index) < MAX_COLS);
	assign depth_ok = (32'(req.depth_index) < MAX_DEPTH);

	assign end_p = (p_q == last_p_q);
	assign end_j = (j_q == last_j_q);
	assign end_i = (i_q == last_i_q);

	assign rd_row_a = i_q;
	assign rd_row_b = j_q;
	assign rd_depth = p_q;

	always_comb begin
		cmd.wr_a        = accept && (req.action == mmtb_pkg::ACT_LOAD_A) && row_ok_a && depth_ok;
		cmd.wr_b        = accept && (req.action == mmtb_pkg::ACT_LOAD_B) && row_ok_b && depth_ok;
		cmd.issue       = (state_q == S_ISSUE);
		cmd.first       = (p_q == '0);
		cmd.last_beat   = end_p;
		cmd.last_result = end_p && end_j && end_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			p_q      <= '0;
			last_i_q <= '0;
			last_j_q <= '0;
			last_p_q <= '0;
			rows_q   <= mmtb_pkg::RST_ROWS;
			cols_q   <= mmtb_pkg::RST_COLS;
			depth_q  <= mmtb_pkg::RST_DEPTH;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					mmtb_pkg::REG_ROWS:  rows_q  <= cfg.data[mmtb_pkg::CNT_W-1:0];
					mmtb_pkg::REG_COLS:  cols_q  <= cfg.data[mmtb_pkg::CNT_W-1:0];
					mmtb_pkg::REG_DEPTH: depth_q <= cfg.data[mmtb_pkg::DEPTH_CNT_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (req.action == mmtb_pkg::ACT_RUN)) begin
						last_i_q <= RW'(mmtb_pkg::clamp_count(int'(rows_q), MAX_ROWS) - 1);
						last_j_q <= CW'(mmtb_pkg::clamp_count(int'(cols_q), MAX_COLS) - 1);
						last_p_q <= DW'(mmtb_pkg::clamp_count(int'(depth_q), MAX_DEPTH) - 1);
						i_q      <= '0;
						j_q      <= '0;
						p_q      <= '0;
						state_q  <= S_START;
					end
				end
				S_START: begin
					if (!st.busy && !st.out_full) begin
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (end_p) begin
						p_q <= '0;
						if (end_j) begin
							j_q <= '0;
							if (end_i) begin
								state_q <= S_IDLE;
							end else begin
								i_q     <= i_q + 1'b1;
								state_q <= S_START;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_START;
						end
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mmtb_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmtb_dp: element stores and multiply-accumulate pipeline
// Two element memories, a registered read stage, a multiplier stage and an
// accumulator that fills the result register at the end of each dot product.
// ----------------------------------------------------------------------------
module mmtb_dp #(
	parameter int MAX_ROWS  = mmtb_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS  = mmtb_pkg::MAX_COLS_DEF,
	parameter int MAX_DEPTH = mmtb_pkg::MAX_DEPTH_DEF
) (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  mmtb_pkg::dp_cmd_t                           cmd,
	output mmtb_pkg::dp_status_t                        st,
	input  wire [mmtb_pkg::ROW_W-1:0]                   ld_row,
	input  wire [mmtb_pkg::DEPTH_IDX_W-1:0]             ld_depth,
	input  wire [mmtb_pkg::ELEM_W-1:0]                  ld_value,
	input  wire [mmtb_pkg::width_of(MAX_ROWS)-1:0]      rd_row_a,
	input  wire [mmtb_pkg::width_of(MAX_COLS)-1:0]      rd_row_b,
	input  wire [mmtb_pkg::width_of(MAX_DEPTH)-1:0]     rd_depth,
	mmtb_rsp_if.source                                  rsp
);

	localparam int RW      = mmtb_pkg::width_of(MAX_ROWS);
	localparam int CW      = mmtb_pkg::width_of(MAX_COLS);
	localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
	localparam int B_DEPTH = MAX_COLS * MAX_DEPTH;
	localparam int AW      = mmtb_pkg::width_of(A_DEPTH);
	localparam int BW      = mmtb_pkg::width_of(B_DEPTH);
	localparam int EW      = mmtb_pkg::ELEM_W;
	localparam int PW      = mmtb_pkg::PROD_W;
	localparam int VW      = mmtb_pkg::VALUE_W;

	logic [EW-1:0] a_mem [A_DEPTH];
	logic [EW-1:0] b_mem [B_DEPTH];

	logic [AW-1:0]        a_wr_addr, a_rd_addr;
	logic [BW-1:0]        b_wr_addr, b_rd_addr;

	logic                 v_s1, first_s1, last_s1, fin_s1;
	logic [RW-1:0]        row_s1;
	logic [CW-1:0]        col_s1;
	logic [EW-1:0]        a_s1, b_s1;

	logic                 v_s2, first_s2, last_s2, fin_s2;
	logic [RW-1:0]        row_s2;
	logic [CW-1:0]        col_s2;
	logic signed [PW-1:0] prod_s2;

	logic signed [VW-1:0] acc_q, sum;
	logic                 out_valid_q;

	assign a_wr_addr = AW'(int'(ld_row) * MAX_DEPTH + int'(ld_depth));
	assign b_wr_addr = BW'(int'(ld_row) * MAX_DEPTH + int'(ld_depth));
	assign a_rd_addr = AW'(int'(rd_row_a) * MAX_DEPTH + int'(rd_depth));
	assign b_rd_addr = BW'(int'(rd_row_b) * MAX_DEPTH + int'(rd_depth));

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			a_mem[a_wr_addr] <= ld_value;
		end
		a_s1 <= a_mem[a_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_b) begin
			b_mem[b_wr_addr] <= ld_value;
		end
		b_s1 <= b_mem[b_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (v_s2 && last_s2) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last_beat;
		fin_s1   <= cmd.last_result;
		row_s1   <= rd_row_a;
		col_s1   <= rd_row_b;

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		fin_s2   <= fin_s1;
		row_s2   <= row_s1;
		col_s2   <= col_s1;
		prod_s2  <= $signed(a_s1) * $signed(b_s1);

		if (v_s2) begin
			acc_q <= sum;
		end
		if (v_s2 && last_s2) begin
			rsp.out_value   <= sum;
			rsp.out_row     <= mmtb_pkg::ROW_W'(row_s2);
			rsp.out_col     <= mmtb_pkg::ROW_W'(col_s2);
			rsp.last_result <= fin_s2;
		end
	end

	assign sum = (first_s2 ? '0 : acc_q) + VW'(prod_s2);

	assign rsp.valid   = out_valid_q;
	assign st.busy     = v_s1 || v_s2;
	assign st.out_full = out_valid_q;

endmodule
`default_nettype wire

// ===== hdl/mmtb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmtb_checker: port-level checks
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module mmtb_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                req_ready,
	input wire                                rsp_valid,
	input wire                                rsp_ready,
	input wire                                rsp_last,
	input wire [mmtb_pkg::VALUE_W-1:0]        rsp_value
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("Result word dropped while stalled.");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_value))
		else $error("Result value changed while stalled.");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
		else $error("Result word directly after the last word of a run.");

	a_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> !req_ready)
		else $error("Input taken while a run is still in progress.");

endmodule

bind matrix_multiply_transposed_b mmtb_checker u_mmtb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_last  (rsp.last_result),
	.rsp_value (rsp.out_value)
);
`default_nettype wire
